// ===== rtl/rlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcd_pkg
// shared types, codes and defaults of the led chain driver
// ----------------------------------------------------------------------------
package rlcd_pkg;

  localparam int MAX_LEDS_DEF = 256;
  localparam int CMD_DEPTH    = 2;
  localparam int PIX_W        = 24;

  localparam logic [7:0] LED_COUNT_RST   = 8'd15;
  localparam logic [7:0] ZERO_HIGH_RST   = 8'd5;
  localparam logic [7:0] ONE_HIGH_RST    = 8'd14;
  localparam logic [7:0] BIT_PERIOD_RST  = 8'd20;

  localparam logic [7:0] CFG_LED_COUNT   = 8'd0;
  localparam logic [7:0] CFG_ZERO_HIGH   = 8'd1;
  localparam logic [7:0] CFG_ONE_HIGH    = 8'd2;
  localparam logic [7:0] CFG_BIT_PERIOD  = 8'd3;

  localparam logic [2:0] ACT_WRITE_RGB   = 3'd0;
  localparam logic [2:0] ACT_WRITE_PACK  = 3'd1;
  localparam logic [2:0] ACT_WRITE_NUM   = 3'd2;
  localparam logic [2:0] ACT_SHOW        = 3'd3;
  localparam logic [2:0] ACT_TICK        = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] packed_value;
  } rlcd_in_t;

  typedef struct packed {
    logic accepted;
    logic line_level;
    logic busy_res;
  } rlcd_out_t;

  typedef struct packed {
    logic [7:0] led_count;
    logic [7:0] zero_high_ticks;
    logic [7:0] one_high_ticks;
    logic [7:0] bit_period_ticks;
  } rlcd_cfg_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_SHOW,
    CMD_TICK
  } rlcd_kind_t;

  // pixel holds green, red, blue from msb down
  typedef struct packed {
    rlcd_kind_t       kind;
    logic [7:0]       index;
    logic [PIX_W-1:0] pixel;
  } rlcd_cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_EXEC,
    BK_WAIT
  } rlcd_bk_state_t;

endpackage

// ===== rtl/rlcd_ram.sv =====
// ----------------------------------------------------------------------------
// rlcd_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module rlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rlcd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rlcd_cmd_fifo
// short queue of decoded commands between front and back end
// ----------------------------------------------------------------------------
module rlcd_cmd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rlcd_pkg::rlcd_cmd_t cmd_in,
  input  logic               pop,
  output rlcd_pkg::rlcd_cmd_t cmd_out,
  output logic               full,
  output logic               empty
);

  localparam int DEPTH = rlcd_pkg::CMD_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  rlcd_pkg::rlcd_cmd_t slot_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign cmd_out = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= cmd_in;
    end
  end

endmodule

// ===== rtl/rlcd_front.sv =====
// ----------------------------------------------------------------------------
// rlcd_front
// takes items in and turns each into a command for the queue
// ----------------------------------------------------------------------------
module rlcd_front (
  input  logic                start,
  output logic                busy,
  input  rlcd_pkg::rlcd_in_t  in_data,
  input  logic                q_full,
  input  logic                clearing,
  output logic                push,
  output rlcd_pkg::rlcd_cmd_t cmd
);

  assign busy = q_full || clearing;
  assign push = start && !busy;

  always_comb begin
    cmd.kind  = rlcd_pkg::CMD_NOP;
    cmd.index = in_data.led_index;
    cmd.pixel = {in_data.packed_value[15:8], in_data.packed_value[23:16],
                 in_data.packed_value[7:0]};
    unique case (in_data.action)
      rlcd_pkg::ACT_WRITE_RGB: begin
        cmd.kind  = rlcd_pkg::CMD_WRITE;
        cmd.pixel = {in_data.green, in_data.red, in_data.blue};
      end
      rlcd_pkg::ACT_WRITE_PACK: begin
        cmd.kind = rlcd_pkg::CMD_WRITE;
      end
      rlcd_pkg::ACT_WRITE_NUM: begin
        cmd.kind  = rlcd_pkg::CMD_WRITE;
        // one-based number, wraps at 8 bits
        cmd.index = in_data.packed_value[31:24] - 8'd1;
      end
      rlcd_pkg::ACT_SHOW: begin
        cmd.kind = rlcd_pkg::CMD_SHOW;
      end
      rlcd_pkg::ACT_TICK: begin
        cmd.kind = rlcd_pkg::CMD_TICK;
      end
      default: begin
        cmd.kind = rlcd_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/rlcd_back.sv =====
// ----------------------------------------------------------------------------
// rlcd_back
// pixel store, clearing pass, bit serializer and result register
// ----------------------------------------------------------------------------
module rlcd_back #(
  parameter int MAX_LEDS = rlcd_pkg::MAX_LEDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rlcd_pkg::rlcd_cfg_t cfg,
  input  rlcd_pkg::rlcd_cmd_t cmd,
  input  logic                q_empty,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  output rlcd_pkg::rlcd_out_t out_data
);

  localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = ((IW > 8) ? IW : 8) + 1;
  localparam logic [CW-1:0] MAXL = CW'(MAX_LEDS);
  localparam int PW = rlcd_pkg::PIX_W;

  rlcd_pkg::rlcd_bk_state_t state_r, state_nxt;
  logic [IW-1:0]       clr_r, clr_nxt;
  logic                sending_r, sending_nxt;
  logic [IW-1:0]       led_r, led_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [7:0]          tick_r, tick_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [PW-1:0]       row_r, row_nxt;
  rlcd_pkg::rlcd_out_t pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  rlcd_pkg::rlcd_out_t out_r, out_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  logic [CW-1:0] lc_ext, active, idx_ext, led_ext, led_inc;
  logic [7:0]    high_ticks;
  logic          level, tick_wrap, byte_end, row_end, last_byte;
  logic          show_go, row_cross;

  rlcd_ram #(.WIDTH(PW), .DEPTH(MAX_LEDS)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign lc_ext     = CW'(cfg.led_count);
  assign active     = (lc_ext < MAXL) ? lc_ext : MAXL;
  assign idx_ext    = CW'(cmd.index);
  assign led_ext    = CW'(led_r);
  assign led_inc    = led_ext + CW'(1);
  assign high_ticks = shift_r[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign level      = sending_r && (tick_r < high_ticks);
  assign tick_wrap  = !(({1'b0, tick_r} + 9'd1) < {1'b0, cfg.bit_period_ticks});
  assign byte_end   = tick_wrap && (bit_r == 3'd7);
  assign row_end    = (k_r == 2'd2);
  assign last_byte  = row_end ? (led_inc >= active) : (led_ext >= active);

  assign pop       = (state_r == rlcd_pkg::BK_EXEC) && !q_empty;
  assign show_go   = pop && (cmd.kind == rlcd_pkg::CMD_SHOW) && !sending_r
                     && (active != '0);
  assign row_cross = pop && (cmd.kind == rlcd_pkg::CMD_TICK) && sending_r
                     && byte_end && row_end && !last_byte;

  assign clearing  = (state_r == rlcd_pkg::BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlcd_pkg::BK_CLEAR: begin
        if (clr_r == IW'(MAX_LEDS - 1)) begin
          state_nxt = rlcd_pkg::BK_EXEC;
        end
      end
      rlcd_pkg::BK_EXEC: begin
        if (show_go || row_cross) begin
          state_nxt = rlcd_pkg::BK_WAIT;
        end
      end
      rlcd_pkg::BK_WAIT: begin
        state_nxt = rlcd_pkg::BK_EXEC;
      end
      default: begin
        state_nxt = rlcd_pkg::BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_nxt       = clr_r;
    sending_nxt   = sending_r;
    led_nxt       = led_r;
    k_nxt         = k_r;
    bit_nxt       = bit_r;
    tick_nxt      = tick_r;
    shift_nxt     = shift_r;
    row_nxt       = row_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_ext[IW-1:0];
    ram_wdata     = cmd.pixel;
    ram_raddr     = led_r;
    unique case (state_r)
      rlcd_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + IW'(1);
      end
      rlcd_pkg::BK_EXEC: begin
        if (pop) begin
          out_nxt.accepted   = 1'b0;
          out_nxt.line_level = level;
          unique case (cmd.kind)
            rlcd_pkg::CMD_WRITE: begin
              if (!sending_r && (idx_ext < active)) begin
                out_nxt.accepted = 1'b1;
                ram_we           = 1'b1;
              end
            end
            rlcd_pkg::CMD_SHOW: begin
              if (!sending_r) begin
                out_nxt.accepted = 1'b1;
                led_nxt          = '0;
                k_nxt            = 2'd0;
                bit_nxt          = 3'd0;
                tick_nxt         = 8'd0;
                if (active != '0) begin
                  sending_nxt = 1'b1;
                  ram_raddr   = '0;
                end
              end
            end
            rlcd_pkg::CMD_TICK: begin
              if (sending_r) begin
                if (!tick_wrap) begin
                  tick_nxt = tick_r + 8'd1;
                end else if (bit_r != 3'd7) begin
                  tick_nxt  = 8'd0;
                  bit_nxt   = bit_r + 3'd1;
                  shift_nxt = {shift_r[6:0], 1'b0};
                end else begin
                  tick_nxt = 8'd0;
                  bit_nxt  = 3'd0;
                  if (last_byte) begin
                    sending_nxt = 1'b0;
                    shift_nxt   = 8'd0;
                    led_nxt     = '0;
                    k_nxt       = 2'd0;
                  end else if (row_end) begin
                    led_nxt   = led_inc[IW-1:0];
                    k_nxt     = 2'd0;
                    ram_raddr = led_inc[IW-1:0];
                  end else begin
                    k_nxt     = k_r + 2'd1;
                    shift_nxt = (k_r == 2'd0) ? row_r[15:8] : row_r[7:0];
                  end
                end
              end
            end
            rlcd_pkg::CMD_NOP: begin
              out_nxt.accepted = 1'b0;
            end
            default: begin
              out_nxt.accepted = 1'b0;
            end
          endcase
          out_nxt.busy_res = sending_nxt;
          if (show_go || row_cross) begin
            pend_nxt = out_nxt;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      rlcd_pkg::BK_WAIT: begin
        row_nxt       = ram_rdata;
        shift_nxt     = ram_rdata[23:16];
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlcd_pkg::BK_CLEAR;
      clr_r       <= '0;
      sending_r   <= 1'b0;
      led_r       <= '0;
      k_r         <= 2'd0;
      bit_r       <= 3'd0;
      tick_r      <= 8'd0;
      shift_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sending_r   <= sending_nxt;
      led_r       <= led_nxt;
      k_r         <= k_nxt;
      bit_r       <= bit_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcd_pkg::BK_CLEAR) |-> !out_valid_r)
    else $error("result strobe during clearing pass");

  a_wait_only_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcd_pkg::BK_WAIT) |-> sending_r)
    else $error("row fetch while line idle");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (tick_r == 8'd0 && bit_r == 3'd0))
    else $error("bit counters not cleared while idle");

  a_wait_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcd_pkg::BK_WAIT) |=> out_valid_r)
    else $error("no result after row fetch");
`endif

endmodule

// ===== rtl/rgb_led_chain_driver_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_led_chain_driver_unit
// one-wire rgb led chain driver with pixel store and bit serializer
// ----------------------------------------------------------------------------
// The back end finishes most items in its exec state, but a show that starts
// sending and a tick that moves the serializer onto the next LED also pass
// through the wait state, because the pixel ram (one 24-bit row per LED) has
// a registered read. A queue of CMD_DEPTH items sits between the front end
// and the back end, so outside the clearing pass busy is high only while it
// is full. After reset a clearing pass writes zeros to all MAX_LEDS rows, one
// row a clock, with busy held high throughout. Every item gives one result,
// shown for one clock on out_valid in the cycle after the back end finishes
// it; the receiver cannot stall.
module rgb_led_chain_driver_unit #(
  parameter int MAX_LEDS = rlcd_pkg::MAX_LEDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rlcd_pkg::rlcd_in_t  in_data,
  output logic                out_valid,
  output rlcd_pkg::rlcd_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  rlcd_pkg::rlcd_cfg_t cfg_r, cfg_nxt;
  rlcd_pkg::rlcd_cmd_t cmd_in, cmd_out;
  logic push, q_full, q_empty, pop, clearing;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rlcd_pkg::CFG_LED_COUNT:  cfg_nxt.led_count        = cfg_wdata;
        rlcd_pkg::CFG_ZERO_HIGH:  cfg_nxt.zero_high_ticks  = cfg_wdata;
        rlcd_pkg::CFG_ONE_HIGH:   cfg_nxt.one_high_ticks   = cfg_wdata;
        rlcd_pkg::CFG_BIT_PERIOD: cfg_nxt.bit_period_ticks = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count        <= rlcd_pkg::LED_COUNT_RST;
      cfg_r.zero_high_ticks  <= rlcd_pkg::ZERO_HIGH_RST;
      cfg_r.one_high_ticks   <= rlcd_pkg::ONE_HIGH_RST;
      cfg_r.bit_period_ticks <= rlcd_pkg::BIT_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rlcd_front u_front (
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .clearing(clearing),
    .push    (push),
    .cmd     (cmd_in)
  );

  rlcd_cmd_fifo u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd_in),
    .pop    (pop),
    .cmd_out(cmd_out),
    .full   (q_full),
    .empty  (q_empty)
  );

  rlcd_back #(.MAX_LEDS(MAX_LEDS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd_out),
    .q_empty  (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
